>>> src/lgti_pkg.sv
package lgti_pkg;

    // request field widths
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int VAL_W      = 48;
    localparam int E_W        = 52;
    localparam int NODE_IN_W  = 6;
    localparam int LOG_W      = 22;   // log2 in Q.16: 6 integer bits, 16 fraction bits
    localparam int FRAC_W     = 16;
    localparam int FLAVORS    = 3;

    localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

    // stream packing
    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 48;

    localparam int OFS_CUR = 0;
    localparam int OFS_TGT = 1;
    localparam int OFS_TYP = 2;
    localparam int OFS_FL  = 3;
    localparam int OFS_N1  = 5;
    localparam int OFS_N2  = 11;
    localparam int OFS_VAL = 17;
    localparam int OFS_E1  = 65;
    localparam int OFS_E2  = 117;

    // request kinds
    localparam logic [KIND_W-1:0] K_LOAD_T  = 2'd0;
    localparam logic [KIND_W-1:0] K_LOAD_D  = 2'd1;
    localparam logic [KIND_W-1:0] K_QUERY_T = 2'd2;
    localparam logic [KIND_W-1:0] K_QUERY_D = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABOVE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BELOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 52;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LOG_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_INV_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NEGLECT_BELOW  = 3'd5;

    localparam logic [LOG_W-1:0] GLS_RST   = 22'd0;
    localparam logic [31:0]      INV_RST   = 32'd65536;
    localparam logic [6:0]       NCNT_RST  = 7'd64;
    localparam logic [E_W-1:0]   ELOW_RST  = 52'd1;
    localparam logic [E_W-1:0]   EHIGH_RST = 52'hF_FFFF_FFFF_FFFF;
    localparam logic [E_W-1:0]   NEG_RST   = 52'd10000;

    // parameter defaults
    localparam int NODES_DEF      = 64;
    localparam int TARGETS_DEF    = 2;
    localparam int VALUE_BITS_DEF = 48;

endpackage

>>> src/lgti_ram.sv
module lgti_ram
#(
    parameter int W     = 48,
    parameter int DEPTH = 1536
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/log_grid_table_interpolator.sv
// Load requests are taken while idle and leave the block ready.
// A query takes one request at a time; a total below the grid is then scaled
// by a 48-bit restoring divide that spends states S_DIV_A and S_DIV_B on each bit.
// Cost is set by the shared 32x32 multiplier: 17 squarings per log2, two per lerp.
// rst_n asynchronously clears control and configuration; tables are not cleared.
module log_grid_table_interpolator
    import lgti_pkg::*;
#(
    parameter int NODES      = NODES_DEF,
    parameter int TARGETS    = TARGETS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // current_sel, target_slot, particle_type, flavor_code[2], node_first[6],
    // node_second[6], entry_value[48], energy_in[52], energy_out[52], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind[2]
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_value[48]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[2]
    output logic [STATUS_W-1:0]   m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int NB   = $clog2(NODES);
    localparam int NW   = $clog2(NODES + 1);
    localparam int ROWS = 2 * TARGETS * 2 * FLAVORS;
    localparam int RW   = $clog2(ROWS);
    localparam int TD   = ROWS * NODES;
    localparam int TAW  = $clog2(TD);
    localparam int DD   = TD * NODES;
    localparam int DAW  = $clog2(DD);
    localparam int SW   = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CHECK   = 5'd1;
    localparam logic [4:0] S_NORM    = 5'd2;   // leading-zero count, 6 binary steps
    localparam logic [4:0] S_SQ      = 5'd3;   // 16 squarings for the fraction bits
    localparam logic [4:0] S_LOGDONE = 5'd4;
    localparam logic [4:0] S_LOC     = 5'd5;
    localparam logic [4:0] S_LOCDONE = 5'd6;
    localparam logic [4:0] S_IDXFIX  = 5'd7;
    localparam logic [4:0] S_RD_A    = 5'd8;
    localparam logic [4:0] S_RD_B    = 5'd9;
    localparam logic [4:0] S_RD_C    = 5'd10;
    localparam logic [4:0] S_LD      = 5'd11;
    localparam logic [4:0] S_LM1     = 5'd12;
    localparam logic [4:0] S_LM2     = 5'd13;
    localparam logic [4:0] S_LS      = 5'd14;
    localparam logic [4:0] S_LA      = 5'd15;
    localparam logic [4:0] S_DIV_A   = 5'd16;
    localparam logic [4:0] S_DIV_B   = 5'd17;
    localparam logic [4:0] S_OUT     = 5'd18;

    // what the shared sub-sequences are working on
    localparam logic [2:0] PH_T    = 3'd0;   // total query
    localparam logic [2:0] PH_D1   = 3'd1;   // log of energy_in
    localparam logic [2:0] PH_D2   = 3'd2;   // log of energy_out
    localparam logic [2:0] PH_DL1  = 3'd3;   // locate incoming
    localparam logic [2:0] PH_DL2  = 3'd4;   // locate outgoing
    localparam logic [2:0] PH_ROW0 = 3'd5;   // lerp along row i1
    localparam logic [2:0] PH_ROW1 = 3'd6;   // lerp along row i1+1
    localparam logic [2:0] PH_FIN  = 3'd7;   // lerp between rows

    // configuration
    logic [LOG_W-1:0] gls_reg;
    logic [31:0]      inv_reg;
    logic [6:0]       ncnt_reg;
    logic [E_W-1:0]   elow_reg;
    logic [E_W-1:0]   ehigh_reg;
    logic [E_W-1:0]   neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gls_reg   <= GLS_RST;
            inv_reg   <= INV_RST;
            ncnt_reg  <= NCNT_RST;
            elow_reg  <= ELOW_RST;
            ehigh_reg <= EHIGH_RST;
            neg_reg   <= NEG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_LOG_START: gls_reg   <= cfg_wdata[LOG_W-1:0];
                CFG_GRID_INV_STEP:  inv_reg   <= cfg_wdata[31:0];
                CFG_NODE_COUNT:     ncnt_reg  <= cfg_wdata[6:0];
                CFG_ENERGY_LOW:     elow_reg  <= cfg_wdata[E_W-1:0];
                CFG_ENERGY_HIGH:    ehigh_reg <= cfg_wdata[E_W-1:0];
                CFG_NEGLECT_BELOW:  neg_reg   <= cfg_wdata[E_W-1:0];
                default: ;
            endcase
        end
    end

    // nodes in use, clamped to [2, NODES]
    logic [NW-1:0] n_used;
    logic [NW-1:0] nlast;

    always_comb
    begin
        if (ncnt_reg < 7'd2)
        begin
            n_used = NW'(2);
        end
        else if (int'(ncnt_reg) > NODES)
        begin
            n_used = NW'(NODES);
        end
        else
        begin
            n_used = NW'(ncnt_reg);
        end
    end

    assign nlast = n_used - NW'(1);

    // request fields
    logic                 in_cur, in_tgt, in_typ;
    logic [1:0]           in_fl;
    logic [NODE_IN_W-1:0] in_n1, in_n2;
    logic [VAL_W-1:0]     in_val;
    logic [E_W-1:0]       in_e1, in_e2;
    logic                 in_bad;
    logic [RW-1:0]        in_row;
    logic                 in_fire;

    assign in_cur = s_tdata[OFS_CUR];
    assign in_tgt = s_tdata[OFS_TGT];
    assign in_typ = s_tdata[OFS_TYP];
    assign in_fl  = s_tdata[OFS_FL +: 2];
    assign in_n1  = s_tdata[OFS_N1 +: NODE_IN_W];
    assign in_n2  = s_tdata[OFS_N2 +: NODE_IN_W];
    assign in_val = s_tdata[OFS_VAL +: VAL_W];
    assign in_e1  = s_tdata[OFS_E1 +: E_W];
    assign in_e2  = s_tdata[OFS_E2 +: E_W];

    assign in_bad  = (int'(in_fl) >= FLAVORS) || (int'(in_tgt) >= TARGETS);
    assign in_row  = RW'(((int'(in_cur) * TARGETS + int'(in_tgt)) * 2 + int'(in_typ))
                         * FLAVORS + int'(in_fl));
    assign in_fire = s_tvalid && s_tready;

    // sequencer registers
    logic [4:0]        state_reg, state_next;
    logic [2:0]        phase_reg, phase_next;
    logic [5:0]        cnt_reg, cnt_next;

    logic              diff_reg, diff_next;
    logic              bad_reg, bad_next;
    logic              below_reg, below_next;
    logic              top_reg, top_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [E_W-1:0]    e1_reg, e1_next;
    logic [E_W-1:0]    e2_reg, e2_next;
    logic [63:0]       z_reg, z_next;
    logic [5:0]        lz_reg, lz_next;
    logic [FRAC_W-1:0] r_reg, r_next;
    logic [LOG_W-1:0]  l1_reg, l1_next;
    logic [LOG_W-1:0]  l2_reg, l2_next;
    logic [LOG_W-1:0]  loca_reg, loca_next;
    logic [LOG_W-1:0]  idx_reg, idx_next;
    logic [NB-1:0]     i1_reg, i1_next;
    logic [NB-1:0]     i2_reg, i2_next;
    logic [FRAC_W:0]   f_reg, f_next;
    logic [FRAC_W:0]   f1_reg, f1_next;
    logic [VAL_W-1:0]  ym_reg, ym_next;
    logic [VAL_W-1:0]  yp_reg, yp_next;
    logic [VAL_W-1:0]  d_reg, d_next;
    logic              dir_reg, dir_next;
    logic [VAL_W-1:0]  hi_reg, hi_next;
    logic [VAL_W-1:0]  m_reg, m_next;
    logic [VAL_W-1:0]  a_reg, a_next;
    logic [VAL_W-1:0]  v_reg, v_next;
    logic [VAL_W-1:0]  q_reg, q_next;
    logic [E_W+1:0]    rem_reg, rem_next;
    logic [VAL_W-1:0]  res_reg, res_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [63:0]       prod_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b;

    // squaring step: Q1.31 square, renormalize, emit one fraction bit
    logic [32:0] sq_t;
    logic        sq_bit;
    logic [31:0] sq_y;

    assign sq_t   = prod_reg[63:31];
    assign sq_bit = sq_t[32];
    assign sq_y   = sq_bit ? sq_t[32:1] : sq_t[31:0];

    // table reads
    logic [NB-1:0]  rd_col;
    logic [NB-1:0]  rd_rownode;
    logic [TAW-1:0] t_raddr, t_waddr;
    logic [DAW-1:0] d_raddr, d_waddr;
    logic [SW-1:0]  t_rdata, d_rdata;
    logic [VAL_W-1:0] rdata;
    logic           t_we, d_we;

    assign rd_col     = (state_reg == S_RD_B) ? (i2_reg + NB'(1)) : i2_reg;
    assign rd_rownode = (phase_reg == PH_ROW1) ? (i1_reg + NB'(1)) : i1_reg;
    assign t_raddr    = TAW'(int'(row_reg) * NODES + int'(rd_col));
    assign d_raddr    = DAW'((int'(row_reg) * NODES + int'(rd_rownode)) * NODES + int'(rd_col));
    assign rdata      = diff_reg ? VAL_W'(d_rdata) : VAL_W'(t_rdata);

    assign t_waddr = TAW'(int'(in_row) * NODES + int'(in_n1));
    assign d_waddr = DAW'((int'(in_row) * NODES + int'(in_n1)) * NODES + int'(in_n2));
    assign t_we    = in_fire && (s_tuser == K_LOAD_T) && !in_bad && (int'(in_n1) < NODES);
    assign d_we    = in_fire && (s_tuser == K_LOAD_D) && !in_bad
                     && (int'(in_n1) < NODES) && (int'(in_n2) < NODES);

    lgti_ram #(
        .W     (SW),
        .DEPTH (TD)
    ) u_total (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (in_val[SW-1:0]),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    lgti_ram #(
        .W     (SW),
        .DEPTH (DD)
    ) u_diff (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (in_val[SW-1:0]),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // handy combinational values
    logic [LOG_W-1:0] lv;
    logic [LOG_W-1:0] loc_idx;
    logic [FRAC_W:0]  loc_f;
    logic [VAL_W-1:0] lerp_v;
    logic [E_W+1:0]   rem_m1, rem_m2;

    assign lv      = {~lz_reg, r_reg};
    assign loc_idx = prod_reg[32 +: LOG_W];
    assign loc_f   = {1'b0, prod_reg[31:16]};
    assign lerp_v  = dir_reg ? (ym_reg + m_reg) : (ym_reg - m_reg);
    assign rem_m1  = rem_reg - {2'b00, elow_reg};
    assign rem_m2  = rem_reg - {1'b0, elow_reg, 1'b0};

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        diff_next  = diff_reg;
        bad_next   = bad_reg;
        below_next = below_reg;
        top_next   = top_reg;
        row_next   = row_reg;
        e1_next    = e1_reg;
        e2_next    = e2_reg;
        z_next     = z_reg;
        lz_next    = lz_reg;
        r_next     = r_reg;
        l1_next    = l1_reg;
        l2_next    = l2_reg;
        loca_next  = loca_reg;
        idx_next   = idx_reg;
        i1_next    = i1_reg;
        i2_next    = i2_reg;
        f_next     = f_reg;
        f1_next    = f1_reg;
        ym_next    = ym_reg;
        yp_next    = yp_reg;
        d_next     = d_reg;
        dir_next   = dir_reg;
        hi_next    = hi_reg;
        m_next     = m_reg;
        a_next     = a_reg;
        v_next     = v_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        mul_a      = 32'd0;
        mul_b      = 32'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (s_tuser == K_QUERY_T || s_tuser == K_QUERY_D))
                begin
                    diff_next  = (s_tuser == K_QUERY_D);
                    bad_next   = in_bad;
                    row_next   = in_row;
                    e1_next    = in_e1;
                    e2_next    = in_e2;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                st_next    = ST_OK;
                res_next   = '0;
                below_next = (e1_reg < elow_reg);
                lz_next    = '0;
                cnt_next   = '0;
                if (bad_reg)
                begin
                    st_next    = ST_ZERO;
                    state_next = S_OUT;
                end
                else if (e1_reg > ehigh_reg)
                begin
                    st_next    = ST_ABOVE;
                    state_next = S_OUT;
                end
                else if (!diff_reg)
                begin
                    if ((e1_reg < neg_reg) && (elow_reg > neg_reg))
                    begin
                        st_next    = ST_BELOW;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        // under the grid the total is taken at energy_low, then scaled
                        z_next     = 64'((e1_reg < elow_reg) ? elow_reg : e1_reg);
                        phase_next = PH_T;
                        state_next = S_NORM;
                    end
                end
                else if (e1_reg < elow_reg)
                begin
                    st_next    = ST_BELOW;
                    state_next = S_OUT;
                end
                else if ((e2_reg >= e1_reg) || (e2_reg == '0))
                begin
                    st_next    = ST_ZERO;
                    state_next = S_OUT;
                end
                else
                begin
                    z_next     = 64'(e1_reg);
                    phase_next = PH_D1;
                    state_next = S_NORM;
                end
            end

            S_NORM:
            begin
                // binary search for the leading one; zero input ends with lz = 63
                case (cnt_reg)
                    6'd0:
                    begin
                        if (z_reg[63:32] == '0)
                        begin
                            z_next  = z_reg << 32;
                            lz_next = lz_reg + 6'd32;
                        end
                    end
                    6'd1:
                    begin
                        if (z_reg[63:48] == '0)
                        begin
                            z_next  = z_reg << 16;
                            lz_next = lz_reg + 6'd16;
                        end
                    end
                    6'd2:
                    begin
                        if (z_reg[63:56] == '0)
                        begin
                            z_next  = z_reg << 8;
                            lz_next = lz_reg + 6'd8;
                        end
                    end
                    6'd3:
                    begin
                        if (z_reg[63:60] == '0)
                        begin
                            z_next  = z_reg << 4;
                            lz_next = lz_reg + 6'd4;
                        end
                    end
                    6'd4:
                    begin
                        if (z_reg[63:62] == '0)
                        begin
                            z_next  = z_reg << 2;
                            lz_next = lz_reg + 6'd2;
                        end
                    end
                    default:
                    begin
                        if (!z_reg[63])
                        begin
                            z_next  = z_reg << 1;
                            lz_next = lz_reg + 6'd1;
                        end
                    end
                endcase
                if (cnt_reg == 6'd5)
                begin
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end

            S_SQ:
            begin
                mul_a = (cnt_reg == '0) ? z_reg[63:32] : sq_y;
                mul_b = mul_a;
                if (cnt_reg != '0)
                begin
                    r_next = {r_reg[FRAC_W-2:0], sq_bit};
                end
                if (cnt_reg == 6'd16)
                begin
                    state_next = S_LOGDONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end

            S_LOGDONE:
            begin
                case (phase_reg)
                    PH_T:
                    begin
                        if (lv >= gls_reg)
                        begin
                            loca_next  = lv - gls_reg;
                            state_next = S_LOC;
                        end
                        else
                        begin
                            idx_next   = '0;
                            f_next     = '0;
                            state_next = S_IDXFIX;
                        end
                    end
                    PH_D1:
                    begin
                        l1_next    = lv;
                        z_next     = 64'(e2_reg);
                        lz_next    = '0;
                        cnt_next   = '0;
                        phase_next = PH_D2;
                        state_next = S_NORM;
                    end
                    default:
                    begin
                        if ((l1_reg < gls_reg) || (lv < gls_reg))
                        begin
                            st_next    = ST_ZERO;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            l2_next    = lv;
                            loca_next  = l1_reg - gls_reg;
                            phase_next = PH_DL1;
                            state_next = S_LOC;
                        end
                    end
                endcase
            end

            S_LOC:
            begin
                mul_a      = 32'(loca_reg);
                mul_b      = inv_reg;
                state_next = S_LOCDONE;
            end

            S_LOCDONE:
            begin
                case (phase_reg)
                    PH_T:
                    begin
                        idx_next   = loc_idx;
                        f_next     = loc_f;
                        state_next = S_IDXFIX;
                    end
                    PH_DL1:
                    begin
                        idx_next   = loc_idx;
                        f1_next    = loc_f;
                        loca_next  = l2_reg - gls_reg;
                        phase_next = PH_DL2;
                        state_next = S_LOC;
                    end
                    default:
                    begin
                        if ((idx_reg > LOG_W'(nlast)) || (loc_idx > LOG_W'(nlast)))
                        begin
                            st_next    = ST_ZERO;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            i1_next = NB'(idx_reg);
                            top_next = (idx_reg == LOG_W'(nlast));
                            // top outgoing node: last pair at full fraction
                            if (loc_idx == LOG_W'(nlast))
                            begin
                                i2_next = NB'(nlast - NW'(1));
                                f_next  = FRAC_ONE;
                            end
                            else
                            begin
                                i2_next = NB'(loc_idx);
                                f_next  = loc_f;
                            end
                            phase_next = PH_ROW0;
                            state_next = S_RD_A;
                        end
                    end
                endcase
            end

            S_IDXFIX:
            begin
                if (idx_reg >= LOG_W'(nlast))
                begin
                    i2_next = NB'(nlast - NW'(1));
                    f_next  = FRAC_ONE;
                end
                else
                begin
                    i2_next = NB'(idx_reg);
                end
                state_next = S_RD_A;
            end

            S_RD_A:
            begin
                state_next = S_RD_B;
            end

            S_RD_B:
            begin
                ym_next    = rdata;
                state_next = S_RD_C;
            end

            S_RD_C:
            begin
                yp_next    = rdata;
                state_next = S_LD;
            end

            S_LD:
            begin
                if (yp_reg >= ym_reg)
                begin
                    d_next   = yp_reg - ym_reg;
                    dir_next = 1'b1;
                end
                else
                begin
                    d_next   = ym_reg - yp_reg;
                    dir_next = 1'b0;
                end
                state_next = S_LM1;
            end

            S_LM1:
            begin
                mul_a      = d_reg[VAL_W-1:16];
                mul_b      = 32'(f_reg);
                state_next = S_LM2;
            end

            S_LM2:
            begin
                hi_next    = prod_reg[VAL_W-1:0];
                mul_a      = 32'(d_reg[15:0]);
                mul_b      = 32'(f_reg);
                state_next = S_LS;
            end

            S_LS:
            begin
                m_next     = hi_reg + VAL_W'(prod_reg[32:16]);
                state_next = S_LA;
            end

            S_LA:
            begin
                case (phase_reg)
                    PH_T:
                    begin
                        if (below_reg)
                        begin
                            v_next     = lerp_v;
                            q_next     = '0;
                            rem_next   = '0;
                            cnt_next   = '0;
                            state_next = S_DIV_A;
                        end
                        else
                        begin
                            res_next   = lerp_v;
                            state_next = S_OUT;
                        end
                    end
                    PH_ROW0:
                    begin
                        a_next = lerp_v;
                        if (top_reg)
                        begin
                            res_next   = lerp_v;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            phase_next = PH_ROW1;
                            state_next = S_RD_A;
                        end
                    end
                    PH_ROW1:
                    begin
                        ym_next    = a_reg;
                        yp_next    = lerp_v;
                        f_next     = f1_reg;
                        phase_next = PH_FIN;
                        state_next = S_LD;
                    end
                    default:
                    begin
                        res_next   = lerp_v;
                        state_next = S_OUT;
                    end
                endcase
            end

            S_DIV_A:
            begin
                // value * energy_in / energy_low, one bit of the value per pass
                rem_next = {rem_reg[E_W:0], 1'b0}
                           + (v_reg[VAL_W-1] ? {2'b00, e1_reg} : '0);
                state_next = S_DIV_B;
            end

            S_DIV_B:
            begin
                if (!rem_m2[E_W+1])
                begin
                    rem_next = rem_m2;
                    q_next   = {q_reg[VAL_W-2:0], 1'b0} + VAL_W'(2);
                end
                else if (!rem_m1[E_W+1])
                begin
                    rem_next = rem_m1;
                    q_next   = {q_reg[VAL_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[VAL_W-2:0], 1'b0};
                end
                v_next = v_reg << 1;
                if (cnt_reg == 6'(VAL_W - 1))
                begin
                    res_next   = q_next;
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 6'd1;
                    state_next = S_DIV_A;
                end
            end

            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_T;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg  <= diff_next;
        bad_reg   <= bad_next;
        below_reg <= below_next;
        top_reg   <= top_next;
        row_reg   <= row_next;
        e1_reg    <= e1_next;
        e2_reg    <= e2_next;
        z_reg     <= z_next;
        lz_reg    <= lz_next;
        r_reg     <= r_next;
        l1_reg    <= l1_next;
        l2_reg    <= l2_next;
        loca_reg  <= loca_next;
        idx_reg   <= idx_next;
        i1_reg    <= i1_next;
        i2_reg    <= i2_next;
        f_reg     <= f_next;
        f1_reg    <= f1_next;
        ym_reg    <= ym_next;
        yp_reg    <= yp_next;
        d_reg     <= d_next;
        dir_reg   <= dir_next;
        hi_reg    <= hi_next;
        m_reg     <= m_next;
        a_reg     <= a_next;
        v_reg     <= v_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        st_reg    <= st_next;
        prod_reg  <= mul_a * mul_b;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = res_reg;
    assign m_tuser  = st_reg;

endmodule

>>> src/lgti_checker.sv
module lgti_checker
    import lgti_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [STATUS_W-1:0]   m_tuser
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // any non-ok status carries a zero value
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("nonzero value with non-ok status");

    // one request in flight: no new request while a result waits
    a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("ready while a result is pending");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == K_QUERY_T || s_tuser == K_QUERY_D)
        |=> !s_tready)
        else $error("ready right after a query");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == K_LOAD_T || s_tuser == K_LOAD_D)
        |=> s_tready)
        else $error("load stalled the input");

endmodule

bind log_grid_table_interpolator lgti_checker u_lgti_checker (.*);
